// ===== src/fmr_pkg.sv =====
// shared types and constants for the floor match remove table
package fmr_pkg;

	localparam int unsigned VAL_W = 32;

	// request opcodes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	// response status codes
	localparam logic [1:0] ST_MATCH    = 2'd0;
	localparam logic [1:0] ST_NOMATCH  = 2'd1;
	localparam logic [1:0] ST_INSERTED = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RESP
	} state_t;

endpackage

// ===== src/fmr_store.sv =====
// value store: one write port, one registered read port
module fmr_store #(
	parameter int unsigned CAPACITY = 256
) (
	input  logic                            clk,
	input  logic                            wr_en,
	input  logic [$clog2(CAPACITY)-1:0]     wr_addr,
	input  logic [fmr_pkg::VAL_W-1:0]       wr_data,
	input  logic                            rd_en,
	input  logic [$clog2(CAPACITY)-1:0]     rd_addr,
	output logic [fmr_pkg::VAL_W-1:0]       rd_data
);
	import fmr_pkg::*;

	logic [VAL_W-1:0] mem [CAPACITY];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered output
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== src/fmr_ctrl.sv =====
// sequencer: insert, linear floor scan, remove by moving the last entry, response register
module fmr_ctrl #(
	parameter int unsigned CAPACITY = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  logic                            opcode,
	input  logic [fmr_pkg::VAL_W-1:0]       value,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output logic [1:0]                      status,
	output logic [fmr_pkg::VAL_W-1:0]       matched_value,
	output logic                            wr_en,
	output logic [$clog2(CAPACITY)-1:0]     wr_addr,
	output logic [fmr_pkg::VAL_W-1:0]       wr_data,
	output logic                            rd_en,
	output logic [$clog2(CAPACITY)-1:0]     rd_addr,
	input  logic [fmr_pkg::VAL_W-1:0]       rd_data
);
	import fmr_pkg::*;

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	state_t          state_q, state_d;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   rd_idx_q;
	logic [CW-1:0]   cmp_idx_q;
	logic            found_q;
	logic [AW-1:0]   best_idx_q;
	logic [VAL_W-1:0] best_val_q;
	logic [VAL_W-1:0] val_q;
	logic [1:0]      res_status_q;
	logic [VAL_W-1:0] res_value_q;
	logic            rsp_valid_q;
	logic [1:0]      rsp_status_q;
	logic [VAL_W-1:0] rsp_value_q;

	logic            full;
	logic            hit;
	logic            found_n;
	logic [AW-1:0]   best_idx_n;
	logic [VAL_W-1:0] best_val_n;
	logic            accept;
	logic            scan_last;
	logic            count_inc;
	logic            count_dec;
	logic            rsp_load;

	// candidate tracking for the floor search
	assign full       = (count_q == CW'(CAPACITY));
	assign hit        = (rd_data <= val_q) && (!found_q || (rd_data > best_val_q));
	assign found_n    = found_q | hit;
	assign best_idx_n = hit ? cmp_idx_q[AW-1:0] : best_idx_q;
	assign best_val_n = hit ? rd_data : best_val_q;

	// next state and memory control
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		accept    = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = rd_idx_q[AW-1:0];
		wr_en     = 1'b0;
		wr_addr   = count_q[AW-1:0];
		wr_data   = value;
		scan_last = 1'b0;
		count_inc = 1'b0;
		count_dec = 1'b0;
		rsp_load  = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					accept = 1'b1;
					if (opcode == OP_INSERT) begin
						state_d = S_RESP;
						if (!full) begin
							wr_en     = 1'b1;
							count_inc = 1'b1;
						end
					end else if (count_q != '0) begin
						rd_en   = 1'b1;
						rd_addr = '0;
						state_d = S_SCAN;
					end else begin
						state_d = S_RESP;
					end
				end
			end
			S_SCAN: begin
				rd_en     = (rd_idx_q < count_q);
				scan_last = ((cmp_idx_q + CW'(1)) == count_q);
				if (scan_last) begin
					state_d = S_RESP;
					// fill the freed slot with the last entry
					if (found_n) begin
						wr_en     = 1'b1;
						wr_addr   = best_idx_n;
						wr_data   = rd_data;
						count_dec = 1'b1;
					end
				end
			end
			S_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (count_inc) begin
				count_q <= count_q + CW'(1);
			end else if (count_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (accept) begin
				found_q <= 1'b0;
			end else if (state_q == S_SCAN) begin
				found_q <= found_n;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// request, scan and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q       <= value;
			rd_idx_q    <= CW'(1);
			cmp_idx_q   <= '0;
			res_value_q <= '0;
			if (opcode == OP_INSERT) begin
				res_status_q <= full ? ST_FULL : ST_INSERTED;
			end else begin
				res_status_q <= ST_NOMATCH;
			end
		end else if (state_q == S_SCAN) begin
			if (rd_en) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end
			cmp_idx_q  <= cmp_idx_q + CW'(1);
			best_idx_q <= best_idx_n;
			best_val_q <= best_val_n;
			if (scan_last && found_n) begin
				res_status_q <= ST_MATCH;
				res_value_q  <= best_val_n;
			end
		end
		if (rsp_load) begin
			rsp_status_q <= res_status_q;
			rsp_value_q  <= res_value_q;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign status        = rsp_status_q;
	assign matched_value = rsp_value_q;

endmodule

// ===== src/floor_match_remove_table.sv =====
// top level of the floor match remove table
// A bounded multiset of 32-bit values held densely in one memory. An insert writes the
// value at the fill position in the accept cycle, unless the table is full. A query
// reads the stored entries one per cycle through the single read port, keeping the
// largest value not above the limit, then, if one is found, moves the last entry into
// the freed slot. One request is worked at a time, while a finished response may wait
// in the output register. Reset clears the fill count and control state but not the
// memory, so no clearing pass is needed.
module floor_match_remove_table #(
	parameter int unsigned CAPACITY = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  logic                            opcode,
	input  logic [fmr_pkg::VAL_W-1:0]       value,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output logic [1:0]                      status,
	output logic [fmr_pkg::VAL_W-1:0]       matched_value
);
	import fmr_pkg::*;

	localparam int unsigned AW = $clog2(CAPACITY);

	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [VAL_W-1:0] wr_data;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic [VAL_W-1:0] rd_data;

	// sequencer
	fmr_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.opcode       (opcode),
		.value        (value),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.status       (status),
		.matched_value(matched_value),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data)
	);

	// value memory
	fmr_store #(
		.CAPACITY(CAPACITY)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

`ifndef SYNTHESIS
	// a write never coincides with a scan read
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("memory write and read in the same cycle");

	// writes stay inside the table
	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (32'(wr_addr) < CAPACITY))
		else $error("memory write beyond capacity");

	// one request at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request accepted while another is in progress");

	// only a match carries a value
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (status != ST_MATCH)) |-> (matched_value == '0))
		else $error("non-match response carries a value");
`endif

endmodule
